[src/cell_monitor_reading_conversion_unit_macros.svh]
// assertion macros for the cell monitor reading conversion unit
`ifndef CELL_MONITOR_READING_CONVERSION_UNIT_MACROS_SVH
`define CELL_MONITOR_READING_CONVERSION_UNIT_MACROS_SVH

// checked property, quiet while reset is asserted
`define CMRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also covers the reset cycles
`define CMRC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cmrc_pkg.sv]
// shared types and constants for the cell monitor reading conversion unit
package cmrc_pkg;

  // command codes
  localparam logic [1:0] CMD_CELL = 2'd0;
  localparam logic [1:0] CMD_PACK = 2'd1;
  localparam logic [1:0] CMD_TEMP = 2'd2;
  localparam logic [1:0] CMD_TRIP = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TRIM_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TRIM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TRIM    = 2'd2;
  localparam int CFG_DATA_W = 8;

  // datapath widths
  localparam int GAIN_W  = 9;   // 365..396 uV per lsb
  localparam int PROD_W  = 25;  // raw * gain
  localparam int NUM_W   = 26;  // trip numerator in uV
  localparam int X_W     = 27;  // dividend of the divide-by-1000 unit
  localparam int Q_W     = 17;  // quotient of the divide-by-1000 unit
  localparam int REM_W   = 21;  // trip divider remainder
  localparam int DSR_W   = 13;  // trip divisor, 16 * gain
  localparam int TRIP_W  = 8;   // trip code
  localparam int VALUE_W = 18;

  localparam logic [GAIN_W-1:0] GAIN_BASE = 9'd365;
  localparam logic signed [23:0] MV_SCALE = 24'sd1000;
  localparam logic signed [23:0] TEMP_REF_UV = 24'sd2185000;
  localparam logic signed [VALUE_W-1:0] TEMP_BASE_DD = 18'sd250;
  localparam logic signed [VALUE_W-1:0] TRIP_MAX = 18'sd255;

  // floor(2^32 / 1000), quotient is exact or one low
  localparam logic [22:0] RECIP_1000 = 23'd4294967;
  localparam int RECIP_SHIFT = 32;
  localparam logic [10:0] DIVISOR_1000 = 11'd1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] raw_value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;
  } out_t;

  // per-item control that rides along the divide stages
  typedef struct packed {
    logic [1:0] cmd;
    logic       sat;
    logic       cap;
    logic       neg;
  } side_t;

endpackage

[src/cmrc_div1000.sv]
// three-stage floor divide by 1000 through a reciprocal multiply and one correction
module cmrc_div1000 (
  input  logic                clk,
  input  logic [2:0]          en,
  input  logic [26:0]         x,
  output logic [16:0]         q
);
  import cmrc_pkg::*;

  logic [X_W+22:0] recip_prod;
  logic [Q_W-1:0]  q0_nxt;
  logic [Q_W-1:0]  q0_r;
  logic [X_W-1:0]  x_r;
  logic [X_W-1:0]  back_prod;
  logic [X_W-1:0]  diff;
  logic [10:0]     rem_r;
  logic [Q_W-1:0]  q1_r;
  logic [Q_W-1:0]  q_r;

  // stage a: estimate
  assign recip_prod = {23'd0, x} * {27'd0, RECIP_1000};
  assign q0_nxt     = recip_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q0_r <= q0_nxt;
      x_r  <= x;
    end
  end

  // stage b: remainder of the estimate, below 2000
  assign back_prod = {10'd0, q0_r} * 27'd1000;
  assign diff      = x_r - back_prod;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem_r <= diff[10:0];
      q1_r  <= q0_r;
    end
  end

  // stage c: correction
  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_r <= q1_r + Q_W'(rem_r >= DIVISOR_1000);
    end
  end

  assign q = q_r;

endmodule

[src/cmrc_tripdiv.sv]
// four-stage restoring divider, two quotient bits per stage, for the trip code
module cmrc_tripdiv (
  input  logic        clk,
  input  logic [3:0]  en,
  input  logic [20:0] rem,
  input  logic [12:0] dsr,
  output logic [7:0]  q
);
  import cmrc_pkg::*;

  localparam int NSTG = 4;

  logic [REM_W-1:0]  rem_r [0:NSTG-2];
  logic [TRIP_W-1:0] quo_r [0:NSTG-1];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int KHI = TRIP_W - 1 - 2 * s;
    localparam int KLO = KHI - 1;

    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  sub_hi;
    logic [REM_W-1:0]  sub_lo;
    logic [REM_W-1:0]  rem_mid;
    logic [REM_W-1:0]  rem_out;
    logic [TRIP_W-1:0] quo_in;
    logic [TRIP_W-1:0] quo_out;
    logic              ge_hi;
    logic              ge_lo;

    if (s == 0) begin : g_first
      assign rem_in = rem;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      sub_hi  = {8'd0, dsr} << KHI;
      sub_lo  = {8'd0, dsr} << KLO;
      ge_hi   = rem_in >= sub_hi;
      rem_mid = ge_hi ? rem_in - sub_hi : rem_in;
      ge_lo   = rem_mid >= sub_lo;
      rem_out = ge_lo ? rem_mid - sub_lo : rem_mid;
      quo_out = quo_in | (TRIP_W'(ge_hi) << KHI) | (TRIP_W'(ge_lo) << KLO);
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        quo_r[s] <= quo_out;
      end
    end

    if (s < NSTG - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem_r[s] <= rem_out;
        end
      end
    end
  end

  assign q = quo_r[NSTG-1];

endmodule

[src/cell_monitor_reading_conversion_unit.sv]
// top level of the cell monitor reading conversion unit
//
// Converts one monitor reading per item into engineering units using the gain
// trim (365 + 5-bit code, uV per lsb) and the signed millivolt offset held in
// three configuration registers. cmd picks cell mV, pack mV, NTC temperature in
// decidegrees, or a millivolt threshold turned into an 8-bit trip code. The
// datapath is a seven-stage pipeline, stage 7 being the output register. A new
// item can be taken every cycle while out_stall is low, so the sustained rate
// is one item per clock. Stage depth is set by the reciprocal multiply of the
// shared divide-by-1000 unit (cell, pack and temperature) and by the restoring
// divider that makes the trip code two bits per stage. Every stage holds its
// item while the next one is full and stalled, so bubbles close up and the input
// keeps accepting while a result waits at the output, until every stage is
// full. Configuration must only be written while no item is in flight.
`include "cell_monitor_reading_conversion_unit_macros.svh"

module cell_monitor_reading_conversion_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cmrc_pkg::in_t                   in_data,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output cmrc_pkg::out_t                  out_data,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [cmrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cmrc_pkg::*;

  // configuration registers
  logic [7:0] gain_trim_high_r;
  logic [7:0] gain_trim_low_r;
  logic [7:0] offset_trim_r;

  // stage valid bits and load enables, stage 7 is the output register
  logic [7:1] v_r;
  logic [7:1] en;

  // stage 1: accepted item
  in_t s1_r;

  // stage 2: product and trip numerator
  logic [1:0]        cmd2_r;
  logic [PROD_W-1:0] prod2_r;
  logic              tneg2_r;
  logic [NUM_W-1:0]  nn2_r;

  // stage 3: divide-by-1000 dividend and per-item flags
  logic [X_W-1:0] x3_r;
  side_t          side_r [3:6];

  // combinational values
  logic [GAIN_W-1:0]         gain;
  logic [DSR_W-1:0]          trip_dsr;
  logic [15:0]               mul_a;
  logic [PROD_W-1:0]         prod_c;
  logic [17:0]               trip_diff;
  logic [NUM_W-1:0]          nn_c;
  logic signed [23:0]        off_ext;
  logic signed [23:0]        off_scaled;
  logic signed [23:0]        prod_s;
  logic signed [23:0]        uv;
  logic signed [23:0]        delta;
  logic [22:0]               delta_mag;
  logic [X_W-1:0]            x_temp;
  logic                      cap_c;
  logic [X_W-1:0]            x3_nxt;
  side_t                     side3_nxt;
  logic [Q_W-1:0]            q6;
  logic [TRIP_W-1:0]         tq6;
  logic signed [VALUE_W-1:0] qs;
  out_t                      out_nxt;
  out_t                      out_r;
  logic                      out_neg;

  // -------------------------------------------------------------------------
  // configuration port
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_trim_high_r <= '0;
      gain_trim_low_r  <= '0;
      offset_trim_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_TRIM_HIGH: gain_trim_high_r <= cfg_wdata;
        CFG_GAIN_TRIM_LOW:  gain_trim_low_r  <= cfg_wdata;
        CFG_OFFSET_TRIM:    offset_trim_r    <= cfg_wdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // gain code bits 4:3 from the high trim byte, bits 2:0 from the low one
  assign gain     = GAIN_BASE + {4'd0, gain_trim_high_r[3:2], gain_trim_low_r[7:5]};
  assign trip_dsr = {gain, 4'd0};

  // -------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or drains
  // -------------------------------------------------------------------------
  always_comb begin
    en[7] = !v_r[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage 1: capture
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r <= in_data;
    end
  end

  // -------------------------------------------------------------------------
  // stage 1 -> 2: raw times gain, trip numerator (threshold - offset) * 1000
  // -------------------------------------------------------------------------
  // pack uses all 16 raw bits, cell and temperature only the low 14
  assign mul_a  = (s1_r.cmd == CMD_PACK) ? s1_r.raw_value : {2'd0, s1_r.raw_value[13:0]};
  assign prod_c = {9'd0, mul_a} * {16'd0, gain};

  assign trip_diff = {2'd0, s1_r.raw_value} - {{10{offset_trim_r[7]}}, offset_trim_r};
  // a negative numerator floors at zero
  assign nn_c = trip_diff[17] ? '0 : NUM_W'({9'd0, trip_diff[16:0]} * 26'd1000);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cmd2_r  <= s1_r.cmd;
      prod2_r <= prod_c;
      tneg2_r <= trip_diff[17];
      nn2_r   <= nn_c;
    end
  end

  // -------------------------------------------------------------------------
  // stage 2 -> 3: build the divide-by-1000 dividend per command
  // -------------------------------------------------------------------------
  always_comb begin
    off_ext    = {{16{offset_trim_r[7]}}, offset_trim_r};
    off_scaled = off_ext * MV_SCALE;
    prod_s     = {1'b0, prod2_r[22:0]};
    uv         = prod_s + off_scaled;
    delta      = TEMP_REF_UV - prod_s;
    delta_mag  = delta[23] ? 23'(-delta) : delta[22:0];
    // |delta| / 800 == floor(5 * |delta| / 4) / 1000
    x_temp     = ({4'd0, delta_mag} + {2'd0, delta_mag, 2'd0}) >> 2;
    // trip code tops out once the numerator reaches 256 * 16 * gain
    cap_c      = nn2_r >= {5'd0, gain, 12'd0};

    x3_nxt        = '0;
    side3_nxt.cmd = cmd2_r;
    side3_nxt.sat = 1'b0;
    side3_nxt.cap = 1'b0;
    side3_nxt.neg = 1'b0;
    unique case (cmd2_r)
      CMD_CELL: begin
        // below zero floors at zero and flags the item
        x3_nxt        = uv[23] ? '0 : {4'd0, uv[22:0]};
        side3_nxt.sat = uv[23];
      end
      CMD_PACK: begin
        x3_nxt = {prod2_r, 2'd0};
      end
      CMD_TEMP: begin
        x3_nxt        = x_temp;
        side3_nxt.neg = delta[23];
      end
      CMD_TRIP: begin
        side3_nxt.cap = cap_c;
        side3_nxt.sat = tneg2_r || cap_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x3_r <= x3_nxt;
    end
  end

  // trip divider starts from the stage 2 numerator, answers at stage 6
  cmrc_tripdiv u_tripdiv (
    .clk (clk),
    .en  (en[6:3]),
    .rem (nn2_r[REM_W-1:0]),
    .dsr (trip_dsr),
    .q   (tq6)
  );

  // -------------------------------------------------------------------------
  // stages 4..6: shared divide by 1000, flags ride alongside
  // -------------------------------------------------------------------------
  cmrc_div1000 u_div1000 (
    .clk (clk),
    .en  (en[6:4]),
    .x   (x3_r),
    .q   (q6)
  );

  // per-item flags from stage 3 through stage 6
  always_ff @(posedge clk) begin
    if (en[3]) begin
      side_r[3] <= side3_nxt;
    end
    for (int k = 4; k <= 6; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage 6 -> 7: final result select into the output register
  // -------------------------------------------------------------------------
  assign qs = {1'b0, q6};

  always_comb begin
    out_nxt.saturated = side_r[6].sat;
    unique case (side_r[6].cmd)
      CMD_CELL: out_nxt.value = qs;
      CMD_PACK: out_nxt.value = qs;
      // truncation toward zero: divide the magnitude, then restore the sign
      CMD_TEMP: out_nxt.value = TEMP_BASE_DD + (side_r[6].neg ? -qs : qs);
      CMD_TRIP: out_nxt.value = side_r[6].cap ? TRIP_MAX : {10'd0, tq6};
      default:  out_nxt.value = qs;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[7];
  assign out_data  = out_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  assign out_neg = out_valid && out_data.value[VALUE_W-1];

  // the input only stalls when every stage is occupied
  `CMRC_ASSERT(a_stall_full, in_stall |-> (&v_r), "input stalled with an empty stage")
  // reset empties the pipeline
  `CMRC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  // only temperature gives negative values, and it never saturates
  `CMRC_ASSERT(a_neg_unsat, out_neg |-> !out_data.saturated, "negative result saturated")

endmodule
